// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Shared codes and types for the positional ordered list: request opcodes,
// result status codes, the controller state encoding and the beat field widths.
// ----------------------------------------------------------------------------
package pol_pkg;

    // Request opcodes carried in the op field of a request beat.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Status codes returned with every result beat.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INS   = 6'b000010,
        S_REM   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_WRV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Fixed field widths of the request and result beats.
    localparam int OP_W    = 2;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

endpackage

// ===== hdl/pol_if.sv =====
// ----------------------------------------------------------------------------
// pol_req_if / pol_rsp_if
// Valid/ready channels for request beats and result beats of the list.
// ----------------------------------------------------------------------------
interface pol_req_if;
    logic                         valid;
    logic                         ready;
    logic [pol_pkg::OP_W-1:0]     op;
    logic [pol_pkg::POS_W-1:0]    position;
    logic [pol_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pol_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pol_pkg::VALUE_W-1:0]  removed_value;
    logic [1:0]                   status;
    logic [pol_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output removed_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input entry_count,
                    output ready);
endinterface

// ===== hdl/pol_entry_ram.sv =====
// ----------------------------------------------------------------------------
// pol_entry_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pol_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, read data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered list of up to CAPACITY entries with insert, remove and clear at a
// 1-based position, held in a single-port-read, single-port-write memory.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Entries live in a memory with one
// read and one write port, so an insert or remove moves one entry per cycle:
// an insert at position p into a list of u entries reads and shifts up the
// entries from u down to p, drains the read pipeline, writes the new value
// and then posts the result; a remove reads the entries from p up to u,
// keeping the first as the removed value and shifting the rest down, drains
// the read pipeline and posts the result. An insert at the tail (p = u+1)
// skips the shift and the drain. Clear, unused opcodes and rejected requests
// go straight to posting the result. The result sits in an output register,
// so a new request is taken while a result still waits. No clearing pass is
// needed after reset; the entry count alone tells which entries are live.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
    parameter int CAPACITY    = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pol_req_if.sink   req,
    pol_rsp_if.source rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

    // Control registers.
    pol_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             is_ins_reg, is_ins_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_first_reg, pend_first_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [AW-1:0]            cur_reg, cur_next;
    logic [AW-1:0]            end_reg, end_next;
    logic [AW-1:0]            k_reg, k_next;
    logic [AW-1:0]            pend_dst_reg, pend_dst_next;
    logic [ENTRY_WIDTH-1:0]   val_reg, val_next;
    logic [ENTRY_WIDTH-1:0]   removed_reg, removed_next;
    pol_pkg::status_t         status_reg, status_next;
    logic [pol_pkg::VALUE_W-1:0] out_removed_reg, out_removed_next;
    pol_pkg::status_t         out_status_reg, out_status_next;
    logic [pol_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    // Memory port signals.
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;

    // Widened views for comparisons and for fitting the fixed port widths.
    logic [CMP_W-1:0]                       pos_w, used_w, k_w, um1_w;
    logic [ENTRY_WIDTH+pol_pkg::VALUE_W-1:0] val_wide;
    logic [ENTRY_WIDTH+pol_pkg::VALUE_W-1:0] removed_wide;
    logic [CNT_W+pol_pkg::COUNT_W-1:0]      count_wide;
    logic                                   in_accept;
    logic                                   out_free;

    assign pos_w        = {{(CMP_W - pol_pkg::POS_W){1'b0}}, req.position};
    assign used_w       = {{(CMP_W - CNT_W){1'b0}}, used_reg};
    assign k_w          = pos_w - 1'b1;
    assign um1_w        = used_w - 1'b1;
    assign val_wide     = {{ENTRY_WIDTH{1'b0}}, req.value};
    assign removed_wide = {{pol_pkg::VALUE_W{1'b0}}, removed_reg};
    assign count_wide   = {{pol_pkg::COUNT_W{1'b0}}, used_reg};

    assign req.ready = (state_reg == pol_pkg::S_IDLE);
    assign in_accept = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Memory access: the shift states stream one read per cycle, and each beat,
    // once its registered read data returns, is written one place up or down.
    assign rd_en   = (state_reg == pol_pkg::S_INS) || (state_reg == pol_pkg::S_REM);
    assign rd_addr = cur_reg;
    assign wr_en   = (pend_valid_reg && !pend_first_reg) || (state_reg == pol_pkg::S_WRV);
    assign wr_addr = (state_reg == pol_pkg::S_WRV) ? k_reg : pend_dst_reg;
    assign wr_data = (state_reg == pol_pkg::S_WRV) ? val_reg : rd_data;

    pol_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Next-state logic for the controller and the result register.
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        is_ins_next      = is_ins_reg;
        cur_next         = cur_reg;
        end_next         = end_reg;
        k_next           = k_reg;
        val_next         = val_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_removed_next = out_removed_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        // The read pipeline follows the read issued this cycle.
        pend_valid_next = rd_en;
        pend_first_next = !is_ins_reg && (cur_reg == k_reg);
        pend_dst_next   = is_ins_reg ? (cur_reg + 1'b1) : (cur_reg - 1'b1);

        // The first beat of a remove is the value taken out.
        if (pend_valid_reg && pend_first_reg)
        begin
            removed_next = rd_data;
        end

        unique case (state_reg)
            pol_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    removed_next = '0;
                    status_next  = pol_pkg::ST_OK;
                    val_next     = val_wide[ENTRY_WIDTH-1:0];
                    k_next       = k_w[AW-1:0];
                    state_next   = pol_pkg::S_DONE;
                    case (pol_pkg::op_t'(req.op))
                        pol_pkg::OP_INSERT:
                        begin
                            is_ins_next = 1'b1;
                            if (pos_w == '0 || pos_w > used_w + 1'b1)
                            begin
                                status_next = pol_pkg::ST_BAD_POS;
                            end
                            else if (used_w == CMP_W'(CAPACITY))
                            begin
                                status_next = pol_pkg::ST_FULL;
                            end
                            else
                            begin
                                used_next = used_reg + 1'b1;
                                cur_next  = um1_w[AW-1:0];
                                end_next  = k_w[AW-1:0];
                                // Appending at the tail needs no shift.
                                state_next = (used_w == k_w) ? pol_pkg::S_WRV : pol_pkg::S_INS;
                            end
                        end
                        pol_pkg::OP_REMOVE:
                        begin
                            is_ins_next = 1'b0;
                            if (used_reg == '0)
                            begin
                                status_next = pol_pkg::ST_EMPTY;
                            end
                            else if (pos_w == '0 || pos_w > used_w)
                            begin
                                status_next = pol_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                used_next  = used_reg - 1'b1;
                                cur_next   = k_w[AW-1:0];
                                end_next   = um1_w[AW-1:0];
                                state_next = pol_pkg::S_REM;
                            end
                        end
                        pol_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                        end
                        default:
                        begin
                            used_next = used_reg;
                        end
                    endcase
                end
            end
            pol_pkg::S_INS:
            begin
                if (cur_reg == end_reg)
                begin
                    state_next = pol_pkg::S_DRAIN;
                end
                else
                begin
                    cur_next = cur_reg - 1'b1;
                end
            end
            pol_pkg::S_REM:
            begin
                if (cur_reg == end_reg)
                begin
                    state_next = pol_pkg::S_DRAIN;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            pol_pkg::S_DRAIN:
            begin
                state_next = is_ins_reg ? pol_pkg::S_WRV : pol_pkg::S_DONE;
            end
            pol_pkg::S_WRV:
            begin
                state_next = pol_pkg::S_DONE;
            end
            pol_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_removed_next = removed_wide[pol_pkg::VALUE_W-1:0];
                    out_status_next  = status_reg;
                    out_count_next   = count_wide[pol_pkg::COUNT_W-1:0];
                    state_next       = pol_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pol_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pol_pkg::S_IDLE;
            used_reg       <= '0;
            is_ins_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_first_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            is_ins_reg     <= is_ins_next;
            pend_valid_reg <= pend_valid_next;
            pend_first_reg <= pend_first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        end_reg         <= end_next;
        k_reg           <= k_next;
        pend_dst_reg    <= pend_dst_next;
        val_reg         <= val_next;
        removed_reg     <= removed_next;
        status_reg      <= status_next;
        out_removed_reg <= out_removed_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_count   = out_count_reg;

    // The entry count never passes the capacity.
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        {{(CMP_W - CNT_W){1'b0}}, used_reg} <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    // No memory write while idle or posting a result.
    a_quiet_outside_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pol_pkg::S_IDLE || state_reg == pol_pkg::S_DONE) |-> !wr_en)
        else $error("memory write outside a shift");

    // A rejected request leaves the count as it was.
    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pol_pkg::S_DONE && status_reg != pol_pkg::ST_OK) |-> $stable(used_reg))
        else $error("count changed by a rejected request");

    // A finished result reaches the output register once the slot is free.
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pol_pkg::S_DONE && out_free) |=> out_valid_reg)
        else $error("result not posted");

endmodule
